@@ rtl/ggqr_pkg.sv @@
`timescale 1ns / 1ps
package ggqr_pkg;
  localparam int MaxColumnsDef = 32;
  localparam int DataW = 32;
  localparam int TolW = 31;
  localparam int RowW = 6;
  localparam logic [31:0] Q30One = 32'h4000_0000;

  typedef enum logic [1:0] {
    OP_ROT_X = 2'd0,
    OP_ROT_Y = 2'd1,
    OP_MUL   = 2'd2
  } mac_op_t;

  typedef enum logic [4:0] {
    S_IDLE, S_RD, S_RX, S_RX2, S_RY, S_RY2, S_ROUT,
    S_DIV, S_DIVW, S_TT, S_TTW, S_SQ, S_SQW, S_RDIV, S_RDIVW,
    S_TR, S_TRW, S_CX, S_CX2, S_CY, S_CY2, S_HX, S_HX2, S_HY, S_HY2, S_DONE,
    S_OUT
  } st_t;

  // Saturate a rounded Q30 product sum to 32 bits
  function automatic logic [31:0] round_q30(input logic signed [65:0] v);
    logic signed [65:0] w;
    logic signed [35:0] q;
    begin
      w = v + 66'sd536870912;
      q = 36'(w >>> 30);
      if (q > 36'sd2147483647) round_q30 = 32'h7fff_ffff;
      else if (q < -36'sd2147483648) round_q30 = 32'h8000_0000;
      else round_q30 = q[31:0];
    end
  endfunction
endpackage

@@ rtl/ggqr_mac.sv @@
`timescale 1ns / 1ps
// Shared multiplier: one 33x33 signed product a cycle while en is high, accumulated until clr restarts the sum.
module ggqr_mac (
  input  logic               clk,
  input  logic               clr,
  input  logic               en,
  input  logic               sub,
  input  logic signed [32:0] a,
  input  logic signed [32:0] b,
  output logic signed [65:0] acc
);
  logic signed [65:0] acc_r;
  logic signed [65:0] prod;
  assign prod = a * b;
  always_ff @(posedge clk) begin
    if (en) begin
      if (clr) acc_r <= sub ? -prod : prod;
      else acc_r <= sub ? acc_r - prod : acc_r + prod;
    end
  end
  assign acc = acc_r;
endmodule

@@ rtl/ggqr_divsqrt.sv @@
`timescale 1ns / 1ps
// Restoring divider and bit pair square root, one bit a cycle.
module ggqr_divsqrt (
  input  logic        clk,
  input  logic        start_div,
  input  logic        start_sqrt,
  input  logic [63:0] num,
  input  logic [63:0] den,
  output logic        busy,
  output logic [63:0] result
);
  logic [63:0] rem_r, rem_nxt, q_r, q_nxt, d_r, d_nxt, n_r, n_nxt;
  logic [6:0]  cnt_r, cnt_nxt;
  logic        sq_r, sq_nxt;
  logic [64:0] trial;
  logic [63:0] bitv;

  always_comb begin
    rem_nxt = rem_r; q_nxt = q_r; d_nxt = d_r; n_nxt = n_r;
    cnt_nxt = cnt_r; sq_nxt = sq_r;
    trial = '0; bitv = '0;
    if (start_div) begin
      rem_nxt = '0; q_nxt = '0; n_nxt = num; d_nxt = den;
      cnt_nxt = 7'd64; sq_nxt = 1'b0;
    end else if (start_sqrt) begin
      rem_nxt = num; q_nxt = '0; cnt_nxt = 7'd32; sq_nxt = 1'b1;
    end else if (cnt_r != '0) begin
      if (!sq_r) begin
        trial = {rem_r, n_r[63]};
        n_nxt = {n_r[62:0], 1'b0};
        if (trial >= {1'b0, d_r}) begin
          rem_nxt = 64'(trial - {1'b0, d_r});
          q_nxt = {q_r[62:0], 1'b1};
        end else begin
          rem_nxt = trial[63:0];
          q_nxt = {q_r[62:0], 1'b0};
        end
      end else begin
        bitv = 64'd1 << (7'(cnt_r - 7'd1) << 1);
        if ({1'b0, rem_r} >= {1'b0, q_r} + {1'b0, bitv}) begin
          rem_nxt = rem_r - (q_r + bitv);
          q_nxt = (q_r >> 1) + bitv;
        end else begin
          q_nxt = q_r >> 1;
        end
      end
      cnt_nxt = cnt_r - 7'd1;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt; q_r <= q_nxt; d_r <= d_nxt; n_r <= n_nxt;
    cnt_r <= cnt_nxt; sq_r <= sq_nxt;
  end
  assign busy = (cnt_r != '0);
  assign result = q_r;
endmodule

@@ rtl/gmres_givens_qr_update_top.sv @@
`timescale 1ns / 1ps
// Channel | Direction | Signals
// in      | input     | in_valid/in_ready, in_req_type, in_entry_value, in_last_element
// out     | output    | out_valid/out_ready, out_row_index ... out_overflow
// cfg     | input     | cfg_valid/cfg_ready, cfg_data
// Per item: a column-limit item goes straight out; an element past the stored
// rotations is passed on unrotated; one with a stored rotation takes four shared
// multiplier passes; a closing element with a zero subdiagonal skips the divider,
// else a 64-step divide, 32-step square root, 64-step reciprocal divide and six
// multiplier passes. A start or a first column element returns nothing.
// Synchronous active-low reset clears control, carries and counts.
// in_ready is low while an item is in work or a result waits on out_ready.
module gmres_givens_qr_update_top #(
  parameter int MAX_COLUMNS = ggqr_pkg::MaxColumnsDef
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_req_type,
  input  logic signed [31:0] in_entry_value,
  input  logic        in_last_element,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [5:0]  out_row_index,
  output logic signed [31:0] out_tri_value,
  output logic        out_column_done,
  output logic signed [31:0] out_rhs_value,
  output logic [30:0] out_residual,
  output logic        out_converged,
  output logic        out_overflow,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [30:0] cfg_data
);
  localparam int CntW = $clog2(MAX_COLUMNS + 1);
  localparam int IdxW = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;

  ggqr_pkg::st_t st_r, st_nxt;
  logic [31:0] cos_mem [MAX_COLUMNS];
  logic [31:0] sin_mem [MAX_COLUMNS];
  logic [31:0] c_rd, s_rd;
  logic [30:0] tol_r;
  logic [31:0] carry_r, rhs_r, val_r, c_r, s_r, nx_r;
  logic [CntW-1:0] ccount_r;
  logic [5:0] ecount_r;
  logic [63:0] t_r, r_r;
  logic big_y_r, neg_r;
  logic [5:0] o_row_r;
  logic [31:0] o_tri_r, o_rhs_r;
  logic [30:0] o_res_r;
  logic o_done_r, o_conv_r, o_ovf_r, o_valid_r;

  logic mac_clr, mac_en, mac_sub;
  logic signed [32:0] mac_a, mac_b;
  logic signed [65:0] acc;
  logic dv_start, sq_start, dv_busy;
  logic [63:0] dv_num, dv_den, dv_res;
  logic [31:0] ax, ay, acc_rq;
  logic [IdxW-1:0] rd_idx;

  ggqr_mac u_mac (.clk, .clr(mac_clr), .en(mac_en), .sub(mac_sub),
                  .a(mac_a), .b(mac_b), .acc);
  ggqr_divsqrt u_ds (.clk, .start_div(dv_start), .start_sqrt(sq_start),
                     .num(dv_num), .den(dv_den), .busy(dv_busy), .result(dv_res));

  assign ax = carry_r[31] ? 32'(-carry_r) : carry_r;
  assign ay = val_r[31] ? 32'(-val_r) : val_r;
  assign acc_rq = ggqr_pkg::round_q30(acc);
  assign rd_idx = IdxW'(ecount_r - 6'd1);

  assign in_ready = (st_r == ggqr_pkg::S_IDLE) && !o_valid_r;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (st_r == ggqr_pkg::S_RD) begin
      c_rd <= cos_mem[rd_idx];
      s_rd <= sin_mem[rd_idx];
    end
    if (st_r == ggqr_pkg::S_DONE) begin
      cos_mem[IdxW'(ccount_r)] <= c_r;
      sin_mem[IdxW'(ccount_r)] <= s_r;
    end
  end

  // multiplier operand select
  always_comb begin
    mac_en = 1'b1; mac_clr = 1'b0; mac_sub = 1'b0;
    mac_a = '0; mac_b = '0;
    unique case (st_r)
      ggqr_pkg::S_RX:  begin mac_clr = 1'b1; mac_a = 33'($signed(c_rd));
                   mac_b = 33'($signed(carry_r)); end
      ggqr_pkg::S_RX2: begin mac_a = 33'($signed(s_rd)); mac_b = 33'($signed(val_r)); end
      ggqr_pkg::S_RY:  begin mac_clr = 1'b1; mac_a = 33'($signed(c_rd));
                   mac_b = 33'($signed(val_r)); end
      ggqr_pkg::S_RY2: begin mac_sub = 1'b1; mac_a = 33'($signed(s_rd));
                   mac_b = 33'($signed(carry_r)); end
      ggqr_pkg::S_TT:  begin mac_clr = 1'b1; mac_a = {1'b0, t_r[31:0]};
                   mac_b = {1'b0, t_r[31:0]}; end
      ggqr_pkg::S_TR:  begin mac_clr = 1'b1; mac_a = {1'b0, t_r[31:0]};
                   mac_b = {1'b0, r_r[31:0]}; end
      ggqr_pkg::S_CX:  begin mac_clr = 1'b1; mac_a = 33'($signed(c_r));
                   mac_b = 33'($signed(carry_r)); end
      ggqr_pkg::S_CX2: begin mac_a = 33'($signed(s_r)); mac_b = 33'($signed(val_r)); end
      ggqr_pkg::S_CY:  begin mac_clr = 1'b1; mac_a = 33'($signed(c_r));
                   mac_b = 33'($signed(rhs_r)); end
      ggqr_pkg::S_HX:  begin mac_clr = 1'b1; mac_a = 33'($signed(s_r));
                   mac_b = 33'($signed(rhs_r)); mac_sub = 1'b1; end
      default: mac_en = 1'b0;
    endcase
  end

  always_comb begin
    st_nxt = st_r;
    dv_start = 1'b0; sq_start = 1'b0; dv_num = '0; dv_den = '0;
    unique case (st_r)
      ggqr_pkg::S_IDLE: if (in_valid && in_ready) begin
        if (!in_req_type) st_nxt = ggqr_pkg::S_IDLE;
        else if (32'(ccount_r) >= 32'(MAX_COLUMNS)) st_nxt = ggqr_pkg::S_OUT;
        else if (in_last_element)
          st_nxt = (in_entry_value == '0) ? ggqr_pkg::S_CX : ggqr_pkg::S_DIV;
        else if (ecount_r == '0) st_nxt = ggqr_pkg::S_IDLE;
        else if (32'(ecount_r) - 32'd1 < 32'(ccount_r)) st_nxt = ggqr_pkg::S_RD;
        else st_nxt = ggqr_pkg::S_ROUT;
      end
      ggqr_pkg::S_RD:  st_nxt = ggqr_pkg::S_RX;
      ggqr_pkg::S_RX:  st_nxt = ggqr_pkg::S_RX2;
      ggqr_pkg::S_RX2: st_nxt = ggqr_pkg::S_RY;
      ggqr_pkg::S_RY:  st_nxt = ggqr_pkg::S_RY2;
      ggqr_pkg::S_RY2: st_nxt = ggqr_pkg::S_ROUT;
      ggqr_pkg::S_ROUT: st_nxt = ggqr_pkg::S_OUT;
      ggqr_pkg::S_DIV: begin
        // smaller magnitude over larger, x wins a tie
        dv_start = 1'b1;
        dv_num = (ay > ax) ? {2'b0, ax, 30'b0} : {2'b0, ay, 30'b0};
        dv_den = (ay > ax) ? {32'b0, ay} : {32'b0, ax};
        st_nxt = ggqr_pkg::S_DIVW;
      end
      ggqr_pkg::S_DIVW: if (!dv_busy) st_nxt = ggqr_pkg::S_TT;
      ggqr_pkg::S_TT:  st_nxt = ggqr_pkg::S_TTW;
      ggqr_pkg::S_TTW: begin
        sq_start = 1'b1;
        dv_num = (64'(ggqr_pkg::Q30One) + 64'(acc[63:30])) << 30;
        st_nxt = ggqr_pkg::S_SQ;
      end
      ggqr_pkg::S_SQ:  st_nxt = ggqr_pkg::S_SQW;
      ggqr_pkg::S_SQW: if (!dv_busy) st_nxt = ggqr_pkg::S_RDIV;
      ggqr_pkg::S_RDIV: begin
        dv_start = 1'b1; dv_num = 64'd1 << 60; dv_den = dv_res;
        st_nxt = ggqr_pkg::S_RDIVW;
      end
      ggqr_pkg::S_RDIVW: if (!dv_busy) st_nxt = ggqr_pkg::S_TR;
      ggqr_pkg::S_TR:  st_nxt = ggqr_pkg::S_TRW;
      ggqr_pkg::S_TRW: st_nxt = ggqr_pkg::S_CX;
      ggqr_pkg::S_CX:  st_nxt = ggqr_pkg::S_CX2;
      ggqr_pkg::S_CX2: st_nxt = ggqr_pkg::S_CY;
      ggqr_pkg::S_CY:  st_nxt = ggqr_pkg::S_CY2;
      ggqr_pkg::S_CY2: st_nxt = ggqr_pkg::S_HX;
      ggqr_pkg::S_HX:  st_nxt = ggqr_pkg::S_HX2;
      ggqr_pkg::S_HX2: st_nxt = ggqr_pkg::S_DONE;
      ggqr_pkg::S_DONE: st_nxt = ggqr_pkg::S_OUT;
      ggqr_pkg::S_OUT: st_nxt = ggqr_pkg::S_IDLE;
      default: st_nxt = ggqr_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ggqr_pkg::S_IDLE; tol_r <= '0; carry_r <= '0; rhs_r <= '0;
      ccount_r <= '0; ecount_r <= '0; o_valid_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (cfg_valid && cfg_ready) tol_r <= cfg_data;
      if (o_valid_r && out_ready) o_valid_r <= 1'b0;
      unique case (st_r)
        ggqr_pkg::S_IDLE: if (in_valid && in_ready) begin
          val_r <= in_entry_value;
          if (!in_req_type) begin
            rhs_r <= in_entry_value; ccount_r <= '0; ecount_r <= '0; carry_r <= '0;
          end else if (32'(ccount_r) >= 32'(MAX_COLUMNS)) begin
            o_row_r <= '0; o_tri_r <= '0; o_done_r <= 1'b0; o_rhs_r <= '0;
            o_res_r <= '0; o_conv_r <= 1'b0; o_ovf_r <= 1'b1;
          end else if (in_last_element) begin
            if (ecount_r == '0) carry_r <= '0;
            c_r <= ggqr_pkg::Q30One; s_r <= '0;
          end else if (ecount_r == '0) begin
            carry_r <= in_entry_value; ecount_r <= 6'd1;
          end else begin
            nx_r <= carry_r;
          end
        end
        ggqr_pkg::S_RY: nx_r <= acc_rq;
        ggqr_pkg::S_ROUT: begin
          o_row_r <= ecount_r - 6'd1; o_tri_r <= nx_r;
          o_done_r <= 1'b0; o_rhs_r <= '0; o_res_r <= '0; o_conv_r <= 1'b0;
          o_ovf_r <= 1'b0;
          carry_r <= (32'(ecount_r) - 32'd1 < 32'(ccount_r)) ? acc_rq : val_r;
          if (ecount_r != 6'd63) ecount_r <= ecount_r + 6'd1;
        end
        ggqr_pkg::S_DIVW: if (!dv_busy) t_r <= dv_res;
        ggqr_pkg::S_RDIVW: if (!dv_busy) r_r <= dv_res;
        ggqr_pkg::S_TRW: begin
          if (big_y_r) begin
            s_r <= r_r[31:0];
            c_r <= neg_r ? 32'(-acc[61:30]) : acc[61:30];
          end else begin
            c_r <= r_r[31:0];
            s_r <= neg_r ? 32'(-acc[61:30]) : acc[61:30];
          end
        end
        ggqr_pkg::S_CY: nx_r <= acc_rq;
        ggqr_pkg::S_HX: o_rhs_r <= acc_rq;
        ggqr_pkg::S_HX2: begin
          rhs_r <= acc_rq;
          o_res_r <= (acc_rq == 32'h8000_0000) ? 31'h7fff_ffff :
                     (acc_rq[31] ? 31'(-acc_rq) : acc_rq[30:0]);
        end
        ggqr_pkg::S_DONE: begin
          o_row_r <= 6'(ccount_r); o_tri_r <= nx_r; o_done_r <= 1'b1;
          o_conv_r <= o_res_r < tol_r; o_ovf_r <= 1'b0;
          carry_r <= '0; ecount_r <= '0; ccount_r <= ccount_r + CntW'(1);
        end
        ggqr_pkg::S_OUT: o_valid_r <= 1'b1;
        default: ;
      endcase
    end
  end

  // sign and magnitude ordering for the new rotation
  always_ff @(posedge clk) begin
    if (st_r == ggqr_pkg::S_DIV) begin
      big_y_r <= ay > ax;
      neg_r <= (carry_r != '0) && (carry_r[31] != val_r[31]);
    end
  end

  assign out_valid = o_valid_r;
  assign out_row_index = o_row_r;
  assign out_tri_value = o_tri_r;
  assign out_column_done = o_done_r;
  assign out_rhs_value = o_rhs_r;
  assign out_residual = o_res_r;
  assign out_converged = o_conv_r;
  assign out_overflow = o_ovf_r;

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r != ggqr_pkg::S_IDLE) |-> !in_ready) else $error("accept while busy");
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(ccount_r) <= 32'(MAX_COLUMNS)) else $error("column count past limit");
  a_done_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_column_done && out_overflow)) else $error("done with overflow");
endmodule

@@ sim/gmres_givens_qr_update_top_tb.sv @@
`timescale 1ns / 1ps
module gmres_givens_qr_update_top_tb;

  localparam int MaxCols = ggqr_pkg::MaxColumnsDef;
  localparam int Q30 = 32'h4000_0000;

  typedef struct packed {
    logic [5:0]  row;
    logic [31:0] tri_v;
    logic        done;
    logic [31:0] rhs;
    logic [30:0] resid;
    logic        conv;
    logic        ovf;
  } qr_res_t;

  typedef struct {
    bit          rt;
    logic [31:0] val;
    bit          last;
    bit          typed;
    qr_res_t     res;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0, in_ready;
  logic in_req_type = 1'b0, in_last_element = 1'b0;
  logic signed [31:0] in_entry_value = '0;
  logic out_valid, out_ready = 1'b0;
  logic [5:0] out_row_index;
  logic signed [31:0] out_tri_value, out_rhs_value;
  logic out_column_done, out_converged, out_overflow;
  logic [30:0] out_residual;
  logic cfg_valid = 1'b0, cfg_ready;
  logic [30:0] cfg_data = '0;

  // predictor state
  logic signed [31:0] rot_cos [MaxCols];
  logic signed [31:0] rot_sin [MaxCols];
  logic signed [31:0] col_carry, rhs_carry;
  int unsigned col_count, elem_count;
  logic [30:0] tol_q;

  qr_res_t pending_q[$];
  int n_items, n_results, n_closed, n_ovf, n_conv, n_err;
  bit hold_out;

  always #2 clk = ~clk;

  gmres_givens_qr_update_top i_dut (.*);

  function automatic logic signed [31:0] round_sat30(longint v);
    longint q;
    q = (v + 64'sd536870912) >>> 30;
    if (q > 64'sd2147483647) return 32'h7fff_ffff;
    if (q < -64'sd2147483648) return 32'h8000_0000;
    return q[31:0];
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned res, bt;
    res = 0;
    bt = 64'd1 << 62;
    while (bt > n) bt = bt >> 2;
    while (bt != 0) begin
      if (n >= res + bt) begin
        n = n - (res + bt);
        res = (res >> 1) + bt;
      end else begin
        res = res >> 1;
      end
      bt = bt >> 2;
    end
    return res;
  endfunction

  task automatic apply_rot(input logic signed [31:0] c, s, x, y,
                           output logic signed [31:0] nx, ny);
    longint a, b;
    a = longint'(c) * longint'(x) + longint'(s) * longint'(y);
    b = longint'(c) * longint'(y) - longint'(s) * longint'(x);
    nx = round_sat30(a);
    ny = round_sat30(b);
  endtask

  task automatic make_rot(input logic signed [31:0] x, y,
                          output logic signed [31:0] c, s);
    longint unsigned ax, ay, num, den, t, u, r, o;
    bit big_y, neg;
    logic signed [31:0] other;
    if (y == 0) begin
      c = Q30;
      s = 0;
      return;
    end
    ax = (x < 0) ? longint'(-longint'(x)) : longint'(x);
    ay = (y < 0) ? longint'(-longint'(y)) : longint'(y);
    big_y = ay > ax;
    num = big_y ? ax : ay;
    den = big_y ? ay : ax;
    t = (num << 30) / den;
    u = 64'd1073741824 + ((t * t) >> 30);
    r = (64'd1 << 60) / int_sqrt(u << 30);
    o = (t * r) >> 30;
    neg = (x != 0) && ((x < 0) != (y < 0));
    other = neg ? -o[31:0] : o[31:0];
    if (big_y) begin
      s = r[31:0];
      c = other;
    end else begin
      c = r[31:0];
      s = other;
    end
  endtask

  task automatic qr_step(input bit rt, input logic signed [31:0] v, input bit last,
                         output bit has, output qr_res_t r);
    int unsigned e, idx;
    logic signed [31:0] nx, ny, c, s, rv, nr, carry;
    r = '0;
    has = 1'b0;
    if (!rt) begin
      rhs_carry = v;
      col_count = 0;
      elem_count = 0;
      col_carry = 0;
      return;
    end
    if (col_count >= MaxCols) begin
      r.ovf = 1'b1;
      has = 1'b1;
      return;
    end
    e = elem_count;
    if (!last) begin
      if (e == 0) begin
        col_carry = v;
        elem_count = 1;
        return;
      end
      idx = e - 1;
      if (idx < col_count) apply_rot(rot_cos[idx], rot_sin[idx], col_carry, v, nx, ny);
      else begin
        nx = col_carry;
        ny = v;
      end
      col_carry = ny;
      if (elem_count < 63) elem_count++;
      r.row = idx[5:0];
      r.tri_v = nx;
      has = 1'b1;
      return;
    end
    // closing subdiagonal: new rotation, then rotate the rhs
    carry = (e == 0) ? 0 : col_carry;
    idx = col_count;
    make_rot(carry, v, c, s);
    apply_rot(c, s, carry, v, nx, ny);
    rot_cos[idx] = c;
    rot_sin[idx] = s;
    apply_rot(c, s, rhs_carry, 0, rv, nr);
    rhs_carry = nr;
    r.resid = (nr == 32'sh8000_0000) ? 31'h7fff_ffff : 31'((nr < 0) ? -nr : nr);
    col_carry = 0;
    elem_count = 0;
    col_count = idx + 1;
    r.row = idx[5:0];
    r.tri_v = nx;
    r.done = 1'b1;
    r.rhs = rv;
    r.conv = r.resid < tol_q;
    has = 1'b1;
  endtask

  function automatic int pick_gap();
    int k;
    k = $urandom_range(0, 99);
    if (k < 50) return 0;
    if (k < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [31:0] rand_val();
    case ($urandom_range(0, 9))
      0: return 32'h0;
      1: case ($urandom_range(0, 3))
           0: return 32'h7fff_ffff;
           1: return 32'h8000_0000;
           2: return 32'h1;
           default: return 32'hffff_ffff;
         endcase
      2, 3: return $urandom;
      default: return $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
    endcase
  endfunction

  task automatic send_item(input bit rt, input logic [31:0] v, input bit last,
                           input bit typed = 1'b0, input qr_res_t texp = '0);
    int gap;
    bit has;
    qr_res_t r;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req_type <= rt;
    in_entry_value <= v;
    in_last_element <= last;
    do @(posedge clk); while (!in_ready);
    qr_step(rt, v, last, has, r);
    if (has) pending_q.push_back(typed ? texp : r);
    n_items++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic write_tol(input logic [30:0] v);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    tol_q = v;
  endtask

  // one restart cycle: beta, then Hessenberg columns of j+2 entries, or of random length when noisy
  task automatic run_restart(input int ncols, input bit noisy);
    int len;
    send_item(1'b0, rand_val(), $urandom_range(0, 1));
    for (int j = 0; j < ncols; j++) begin
      len = j + 2;
      if (noisy && $urandom_range(0, 3) == 0) len = $urandom_range(1, j + 4);
      for (int k = 0; k < len; k++) send_item(1'b1, rand_val(), k == len - 1);
    end
  endtask

  task automatic run_random(input int target);
    while (n_items < target) begin
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, 5))
          send_item($urandom_range(0, 1), $urandom, $urandom_range(0, 1));
      end else begin
        run_restart($urandom_range(1, 6), $urandom_range(0, 4) == 0);
      end
    end
  endtask

  task automatic chk(input string name, input logic [31:0] e, a);
    if (e !== a) begin
      $display("%0t: %s mismatch expected %h actual %h", $time, name, e, a);
      n_err++;
    end
  endtask

  always @(posedge clk) begin
    qr_res_t x;
    if (rst_n && out_valid && out_ready) begin
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected result expected none actual row %0d", $time, out_row_index);
        n_err++;
      end else begin
        x = pending_q.pop_front();
        chk("row_index", x.row, out_row_index);
        chk("tri_value", x.tri_v, out_tri_value);
        chk("column_done", x.done, out_column_done);
        chk("rhs_value", x.rhs, out_rhs_value);
        chk("residual", x.resid, out_residual);
        chk("converged", x.conv, out_converged);
        chk("overflow", x.ovf, out_overflow);
      end
      n_results++;
      n_closed += out_column_done;
      n_ovf += out_overflow;
      n_conv += out_converged;
    end
  end

  // receiver: random back-pressure, one long hold-off on request
  initial begin
    @(posedge rst_n);
    forever begin
      if (hold_out) begin
        out_ready <= 1'b0;
        repeat (1500) @(posedge clk);
        hold_out = 1'b0;
      end else begin
        out_ready <= ($urandom_range(0, 9) < 7);
        repeat (pick_gap() + 1) @(posedge clk);
      end
    end
  end

  initial begin
    #20_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    stim_row_t dir_q[$];
    qr_res_t te;
    tol_q = '0;
    col_carry = 0;
    rhs_carry = 0;
    col_count = 0;
    elem_count = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    write_tol(31'h0);

    dir_q.push_back('{1'b0, 32'h0001_0000, 1'b0, 1'b0, '0});
    te = '0; te.tri_v = 32'h0001_0000; te.done = 1; te.resid = 31'h0001_0000;
    dir_q.push_back('{1'b1, 32'h0001_0000, 1'b1, 1'b1, te});
    dir_q.push_back('{1'b1, 32'h7fff_ffff, 1'b0, 1'b0, '0});
    te = '0; te.tri_v = 32'h8000_0000;
    dir_q.push_back('{1'b1, 32'h8000_0000, 1'b0, 1'b1, te});
    // zero subdiagonal: identity rotation
    te = '0; te.row = 1; te.tri_v = 32'h8000_0001; te.done = 1; te.rhs = 32'hffff_0000;
    dir_q.push_back('{1'b1, 32'h0, 1'b1, 1'b1, te});
    dir_q.push_back('{1'b0, 32'h8000_0000, 1'b1, 1'b0, '0});
    dir_q.push_back('{1'b1, 32'h8000_0000, 1'b1, 1'b0, '0});
    // tie in magnitude with opposite signs
    dir_q.push_back('{1'b1, 32'h0003_0000, 1'b0, 1'b0, '0});
    dir_q.push_back('{1'b1, 32'hfffd_0000, 1'b0, 1'b0, '0});
    dir_q.push_back('{1'b1, 32'h0003_0000, 1'b1, 1'b0, '0});
    // long column past the stored rotations, then a short one
    dir_q.push_back('{1'b0, 32'h0002_8000, 1'b0, 1'b0, '0});
    for (int k = 0; k < 5; k++)
      dir_q.push_back('{1'b1, 32'h0001_0000 * (k + 1), k == 4, 1'b0, '0});
    dir_q.push_back('{1'b1, 32'hffff_8000, 1'b0, 1'b0, '0});
    dir_q.push_back('{1'b1, 32'h7fff_ffff, 1'b1, 1'b0, '0});
    dir_q.push_back('{1'b1, 32'h0000_0001, 1'b1, 1'b0, '0});
    dir_q.push_back('{1'b1, 32'hffff_ffff, 1'b1, 1'b0, '0});
    foreach (dir_q[i])
      send_item(dir_q[i].rt, dir_q[i].val, dir_q[i].last, dir_q[i].typed, dir_q[i].res);
    drain();

    write_tol(31'h7fff_ffff);
    hold_out = 1'b1;
    run_random(400);
    drain();

    write_tol(31'($urandom));
    run_restart(MaxCols + 2, 1'b0);  // runs into the column limit
    run_random(1100);
    drain();

    write_tol(31'h0001_0000);
    // element counter saturation
    send_item(1'b0, rand_val(), 1'b0);
    for (int k = 0; k < 70; k++) send_item(1'b1, rand_val(), k == 69);
    run_random(1550);
    drain();

    $display("Sent %0d items over four tolerance settings; %0d results, %0d closed columns,",
             n_items, n_results, n_closed);
    $display("%0d column-limit flags and %0d converged flags.", n_ovf, n_conv);
    if (n_err == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
